### hdl/assert_macros.svh
// assertion helper macros included by the framer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, skipped while rst_n is low
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/ssnf_pkg.sv
// types and constants shared by the seven-segment number framer
`timescale 1ns / 1ps
`default_nettype none
package ssnf_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIV_STEPS  = 4;                    // quotient bits per cycle
  localparam int DIV_CYCLES = VALUE_W / DIV_STEPS;

  localparam logic [1:0] CMD_SHOW   = 2'd0;
  localparam logic [1:0] CMD_BRIGHT = 2'd1;
  localparam logic [1:0] CMD_FILL   = 2'd2;

  localparam logic [2:0] COUNT_RESET = 3'd6;

  localparam logic [7:0] BYTE_DATA_CMD = 8'h40;
  localparam logic [7:0] BYTE_ADDR_CMD = 8'hc0;
  localparam logic [7:0] BYTE_BRIGHT   = 8'h87;
  localparam logic [7:0] SEP_MASK      = 8'h80;
  localparam logic [3:0] BRIGHT_MAX    = 4'd8;

  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_DATA  = 2'd1,
    SYM_STOP  = 2'd2
  } sym_kind_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [3:0]         remainder;
  } div_res_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] p;
    case (digit)
      4'h0: p = 8'h3f;
      4'h1: p = 8'h06;
      4'h2: p = 8'h5b;
      4'h3: p = 8'h4f;
      4'h4: p = 8'h66;
      4'h5: p = 8'h6d;
      4'h6: p = 8'h7d;
      4'h7: p = 8'h07;
      4'h8: p = 8'h7f;
      4'h9: p = 8'h6f;
      4'ha: p = 8'h77;
      4'hb: p = 8'h7c;
      4'hc: p = 8'h39;
      4'hd: p = 8'h5e;
      4'he: p = 8'h79;
      4'hf: p = 8'h71;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

### hdl/ssnf_divider.sv
// iterative radix divider: 32-bit value by a 2..16 divisor, DIV_STEPS quotient bits per cycle
`timescale 1ns / 1ps
`default_nettype none
module ssnf_divider (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start_i,
  input  wire logic [ssnf_pkg::VALUE_W-1:0] dividend_i,
  input  wire logic [4:0]                   divisor_i,
  output ssnf_pkg::div_res_t                res_o
);
  import ssnf_pkg::*;

  localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] quo_r, quo_nxt;
  logic [3:0]         rem_r, rem_nxt;
  logic [4:0]         div_r, div_nxt;

  logic [VALUE_W-1:0] quo_v;
  logic [3:0]         rem_v;
  logic [4:0]         sh;
  logic [4:0]         diff;

  // restoring division, dividend bits shift out on top, quotient bits in at bottom
  always_comb begin
    quo_v = quo_r;
    rem_v = rem_r;
    sh    = '0;
    diff  = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      sh    = {rem_v, quo_v[VALUE_W-1]};
      quo_v = {quo_v[VALUE_W-2:0], 1'b0};
      diff  = sh - div_r;
      if (sh >= div_r) begin
        rem_v    = diff[3:0];
        quo_v[0] = 1'b1;
      end else begin
        rem_v = sh[3:0];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend_i;
      rem_nxt  = '0;
      div_nxt  = divisor_i;
    end else if (busy_r) begin
      quo_nxt = quo_v;
      rem_nxt = rem_v;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign res_o.done      = done_r;
  assign res_o.quotient  = quo_r;
  assign res_o.remainder = rem_r;

endmodule
`default_nettype wire

### hdl/seven_segment_number_framer.sv
// Seven-segment number framer: turns display commands into bus symbol words
// (start, data byte, stop). Show-number extracts one digit at a time with a
// shared radix divider that retires 4 quotient bits per cycle; each digit
// passes through a divider start state and then a wait state until the
// divider reports done. One symbol word leaves per cycle when the output side
// keeps tready high. in_tready is high only between items. digit_count is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the block is idle, which the block itself leaves unchecked. 0 acts as 1 and
// values above MAX_DIGITS act as MAX_DIGITS. Command code 3 produces no words.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module seven_segment_number_framer #(
  parameter int MAX_DIGITS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,  // digit_count
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // number_value[31:0], number_base[36:32], separator_pos[39:37],
  // brightness_level[43:40], raw_pattern[51:44], zero pad[55:52]
  input  wire logic [55:0] in_tdata,
  input  wire logic [1:0]  in_tuser,     // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,    // data_byte
  output logic [1:0]       out_tuser,    // symbol_kind
  output logic             out_tlast     // last_symbol
);
  import ssnf_pkg::*;

  localparam int DIDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    EP_START0,
    EP_DATA_CMD,
    EP_STOP0,
    EP_START1,
    EP_ADDR_CMD,
    EP_DIGITS,
    EP_STOP1
  } emit_ph_t;

  state_t             state_r, state_nxt;
  emit_ph_t           ph_r, ph_nxt;
  logic [2:0]         count_r, count_nxt;
  logic               bright_r, bright_nxt;
  logic [DIDX_W-1:0]  dig_r, dig_nxt;
  logic [DIDX_W-1:0]  last_dig_r, last_dig_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [4:0]         base_r, base_nxt;
  logic [2:0]         sep_r, sep_nxt;
  logic [7:0]         bbyte_r, bbyte_nxt;
  logic [7:0]         digits_r [MAX_DIGITS];
  logic [7:0]         digits_nxt [MAX_DIGITS];

  logic               out_valid_r, out_valid_nxt;
  sym_kind_t          out_kind_r, out_kind_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;

  logic               accept;
  logic               load;
  logic [2:0]         eff_n;
  logic [4:0]         in_base;
  logic [3:0]         in_level;
  logic [3:0]         lvl_sat;
  logic [7:0]         digit_pat;
  sym_kind_t          sym_kind;
  logic [7:0]         sym_byte;
  logic               sym_last;
  div_res_t           div_res;

  ssnf_divider u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (state_r == ST_DIV_START),
    .dividend_i (value_r),
    .divisor_i  (base_r),
    .res_o      (div_res)
  );

  assign accept   = in_tvalid && in_tready;
  assign load     = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign in_base  = in_tdata[36:32];
  assign in_level = in_tdata[43:40];

  always_comb begin
    if (count_r == 3'd0) begin
      eff_n = 3'd1;
    end else if (count_r > 3'(MAX_DIGITS)) begin
      eff_n = 3'(MAX_DIGITS);
    end else begin
      eff_n = count_r;
    end
    lvl_sat   = (in_level > BRIGHT_MAX) ? BRIGHT_MAX : in_level;
    digit_pat = seg_pattern(div_res.remainder) |
                ((sep_r == 3'(dig_r)) ? SEP_MASK : 8'h00);
  end

  // symbol for the current emit phase
  always_comb begin
    sym_kind = SYM_STOP;
    sym_byte = 8'h00;
    sym_last = 1'b0;
    case (ph_r)
      EP_START0: begin
        sym_kind = SYM_START;
      end
      EP_DATA_CMD: begin
        sym_kind = SYM_DATA;
        sym_byte = bright_r ? bbyte_r : BYTE_DATA_CMD;
      end
      EP_STOP0: begin
        sym_kind = SYM_STOP;
        sym_last = bright_r;
      end
      EP_START1: begin
        sym_kind = SYM_START;
      end
      EP_ADDR_CMD: begin
        sym_kind = SYM_DATA;
        sym_byte = BYTE_ADDR_CMD;
      end
      EP_DIGITS: begin
        sym_kind = SYM_DATA;
        sym_byte = digits_r[dig_r];
      end
      EP_STOP1: begin
        sym_kind = SYM_STOP;
        sym_last = 1'b1;
      end
      default: begin
        sym_kind = SYM_STOP;
        sym_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    ph_nxt       = ph_r;
    count_nxt    = count_r;
    bright_nxt   = bright_r;
    dig_nxt      = dig_r;
    last_dig_nxt = last_dig_r;
    value_nxt    = value_r;
    base_nxt     = base_r;
    sep_nxt      = sep_r;
    bbyte_nxt    = bbyte_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digits_nxt[i] = digits_r[i];
    end
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;

    if (cfg_wr_en) begin
      count_nxt = cfg_wr_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          value_nxt    = in_tdata[31:0];
          sep_nxt      = in_tdata[39:37];
          bbyte_nxt    = BYTE_BRIGHT + {4'b0000, lvl_sat};
          last_dig_nxt = DIDX_W'(eff_n - 3'd1);
          ph_nxt       = EP_START0;
          if (in_base < 5'd2) begin
            base_nxt = 5'd2;
          end else if (in_base > 5'd16) begin
            base_nxt = 5'd16;
          end else begin
            base_nxt = in_base;
          end
          case (in_tuser)
            CMD_SHOW: begin
              bright_nxt = 1'b0;
              dig_nxt    = '0;
              state_nxt  = ST_DIV_START;
            end
            CMD_BRIGHT: begin
              bright_nxt = 1'b1;
              state_nxt  = ST_EMIT;
            end
            CMD_FILL: begin
              bright_nxt = 1'b0;
              dig_nxt    = DIDX_W'(eff_n - 3'd1);
              for (int i = 0; i < MAX_DIGITS; i++) begin
                digits_nxt[i] = in_tdata[51:44];
              end
              state_nxt = ST_EMIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          digits_nxt[dig_r] = digit_pat;
          value_nxt         = div_res.quotient;
          if (dig_r == last_dig_r) begin
            state_nxt = ST_EMIT;
          end else begin
            dig_nxt   = dig_r + 1'b1;
            state_nxt = ST_DIV_START;
          end
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = sym_kind;
          out_byte_nxt  = sym_byte;
          out_last_nxt  = sym_last;
          if (sym_last) begin
            state_nxt = ST_IDLE;
          end else if (ph_r == EP_DIGITS) begin
            // most significant digit first, counting down to position zero
            if (dig_r == '0) begin
              ph_nxt = EP_STOP1;
            end else begin
              dig_nxt = dig_r - 1'b1;
            end
          end else begin
            ph_nxt = emit_ph_t'(ph_r + 3'd1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= EP_START0;
      count_r     <= COUNT_RESET;
      bright_r    <= 1'b0;
      dig_r       <= '0;
      last_dig_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      count_r     <= count_nxt;
      bright_r    <= bright_nxt;
      dig_r       <= dig_nxt;
      last_dig_r  <= last_dig_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r    <= value_nxt;
    base_r     <= base_nxt;
    sep_r      <= sep_nxt;
    bbyte_r    <= bbyte_nxt;
    digits_r   <= digits_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `ASSERT_SYNC(a_div_done_in_wait, div_res.done |-> (state_r == ST_DIV_WAIT),
               "divider finished outside the wait state")
  `ASSERT_NEVER(a_dig_in_range, (state_r != ST_IDLE) && (dig_r > last_dig_r),
                "digit index past the digit count")
  `ASSERT_SYNC(a_last_to_idle, (load && sym_last) |=> (state_r == ST_IDLE),
               "frame ended but sequencer not idle")
  `ASSERT_SYNC(a_busy_holds_word, (state_r != ST_EMIT && out_valid_r && !out_tready)
               |=> out_valid_r, "waiting word dropped")

endmodule
`default_nettype wire
